// ===== sv/dfc_pkg.sv =====
package dfc_pkg;

  // Defaults for the top-level parameters
  localparam int FRAME_PIXELS_LOG2_DEF   = 18;
  localparam int DEPTH_FRACTION_BITS_DEF = 4;

  // Field widths
  localparam int DEPTH_W = 20;
  localparam int MM_W    = 16;
  localparam int CH_W    = 8;
  localparam int CNT_W   = 19;
  localparam int SUM_W   = 38;
  localparam int SEC_W   = 3;

  // Fraction within one hue sector; sized for the largest sector
  // (1000 mm at eight fraction bits = 256000)
  localparam int FRAC_W   = 18;
  // floor(n * 255 / 2^F) stays below 255001
  localparam int SCALED_W = 18;

  // Divide by 1000: floor(v * 1048 / 2^20) is q or q - 1 for v < 2^18
  localparam int RECIP_1000  = 1048;
  localparam int RECIP_SHIFT = 20;
  localparam int SECTOR_MM   = 1000;

  // Queue depths (powers of two)
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // Hue sectors
  localparam logic [SEC_W-1:0] SEC_RED   = 3'd0;  // red full, green rising
  localparam logic [SEC_W-1:0] SEC_YEL   = 3'd1;  // green full, red falling
  localparam logic [SEC_W-1:0] SEC_GREEN = 3'd2;  // green full, blue rising
  localparam logic [SEC_W-1:0] SEC_CYAN  = 3'd3;  // blue full, green falling
  localparam logic [SEC_W-1:0] SEC_BLUE  = 3'd4;  // blue full

  // Classified pixel from the front end
  typedef struct packed {
    logic [MM_W-1:0]    whole_mm;
    logic               valid;
    logic [SEC_W-1:0]   sector;
    logic [FRAC_W-1:0]  frac;
    logic [CNT_W-1:0]   count;
    logic [DEPTH_W-1:0] min_d;
    logic [DEPTH_W-1:0] max_d;
    logic [SUM_W-1:0]   sum;
    logic               last;
  } dfc_mid_t;

  // Finished result beat
  typedef struct packed {
    logic [MM_W-1:0]    whole_mm;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [CNT_W-1:0]   valid_count;
    logic [DEPTH_W-1:0] min_depth;
    logic [DEPTH_W-1:0] max_depth;
    logic [SUM_W-1:0]   depth_sum;
    logic               frame_done;
  } dfc_res_t;

endpackage

// ===== sv/dfc_fifo.sv =====
module dfc_fifo import dfc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     level
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign level   = count_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== sv/dfc_front.sv =====
module dfc_front import dfc_pkg::*; #(
  parameter int FRAME_PIXELS_LOG2   = FRAME_PIXELS_LOG2_DEF,
  parameter int DEPTH_FRACTION_BITS = DEPTH_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [DEPTH_W-1:0] depth_q,
  input  logic               is_finite,
  input  logic               frame_last,
  input  logic               mid_full,
  output logic               mid_push,
  output dfc_mid_t           mid_ent
);

  localparam logic [DEPTH_W-1:0] Base  = DEPTH_W'(500 << DEPTH_FRACTION_BITS);
  localparam logic [DEPTH_W-1:0] Unit1 = DEPTH_W'(1000 << DEPTH_FRACTION_BITS);
  localparam logic [DEPTH_W-1:0] Unit2 = DEPTH_W'(2000 << DEPTH_FRACTION_BITS);
  localparam logic [DEPTH_W-1:0] Unit3 = DEPTH_W'(3000 << DEPTH_FRACTION_BITS);
  localparam logic [DEPTH_W-1:0] Unit4 = DEPTH_W'(4000 << DEPTH_FRACTION_BITS);
  localparam logic [CNT_W-1:0] CountLimit = (FRAME_PIXELS_LOG2 < CNT_W) ?
                                             CNT_W'(1 << FRAME_PIXELS_LOG2) :
                                             {CNT_W{1'b1}};

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [DEPTH_W-1:0] min_r, min_nxt;
  logic [DEPTH_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;

  logic               valid;
  logic [DEPTH_W-1:0] mm_full;
  logic [DEPTH_W-1:0] t_raw, t_clip, sec_base;
  logic [SEC_W-1:0]   sector;
  logic [CNT_W-1:0]   count_new;
  logic [DEPTH_W-1:0] min_new, max_new;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_new;

  assign mid_push = push && !mid_full;
  assign valid    = is_finite && (depth_q != '0);
  assign mm_full  = depth_q >> DEPTH_FRACTION_BITS;

  // Hue sector and offset inside it
  always_comb begin
    t_raw  = (depth_q > Base) ? depth_q - Base : '0;
    t_clip = (t_raw > Unit4) ? Unit4 : t_raw;
    if (t_clip >= Unit4) begin
      sector = SEC_BLUE;  sec_base = Unit4;
    end else if (t_clip >= Unit3) begin
      sector = SEC_CYAN;  sec_base = Unit3;
    end else if (t_clip >= Unit2) begin
      sector = SEC_GREEN; sec_base = Unit2;
    end else if (t_clip >= Unit1) begin
      sector = SEC_YEL;   sec_base = Unit1;
    end else begin
      sector = SEC_RED;   sec_base = '0;
    end
  end

  // Running statistics including this pixel
  always_comb begin
    sum_ext   = {1'b0, sum_r} + (SUM_W+1)'(depth_q);
    count_new = count_r;
    min_new   = min_r;
    max_new   = max_r;
    sum_new   = sum_r;
    if (valid) begin
      if (count_r < CountLimit) begin
        count_new = count_r + 1'b1;
      end
      if (depth_q < min_r) begin
        min_new = depth_q;
      end
      if (depth_q > max_r) begin
        max_new = depth_q;
      end
      sum_new = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end
  end

  always_comb begin
    mid_ent.whole_mm = '0;
    if (valid) begin
      mid_ent.whole_mm = (|mm_full[DEPTH_W-1:MM_W]) ? {MM_W{1'b1}} : mm_full[MM_W-1:0];
    end
    mid_ent.valid  = valid;
    mid_ent.sector = sector;
    mid_ent.frac   = FRAC_W'(t_clip - sec_base);
    mid_ent.count  = count_new;
    mid_ent.min_d  = (count_new != '0) ? min_new : '0;
    mid_ent.max_d  = max_new;
    mid_ent.sum    = sum_new;
    mid_ent.last   = frame_last;
  end

  always_comb begin
    count_nxt = count_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    if (mid_push) begin
      if (frame_last) begin
        count_nxt = '0;
        min_nxt   = '1;
        max_nxt   = '0;
        sum_nxt   = '0;
      end else begin
        count_nxt = count_new;
        min_nxt   = min_new;
        max_nxt   = max_new;
        sum_nxt   = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '1;
      max_r   <= '0;
      sum_r   <= '0;
    end else begin
      count_r <= count_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

// ===== sv/dfc_back.sv =====
module dfc_back import dfc_pkg::*; #(
  parameter int DEPTH_FRACTION_BITS = DEPTH_FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dfc_mid_t                   mid_ent,
  input  logic                       mid_empty,
  output logic                       mid_pop,
  input  logic [$clog2(OUT_DEPTH):0] out_level,
  output logic                       res_push,
  output dfc_res_t                   res
);

  localparam int LW = $clog2(OUT_DEPTH) + 2;
  localparam logic [FRAC_W-1:0] Unit = FRAC_W'(SECTOR_MM << DEPTH_FRACTION_BITS);

  logic                  a_vld_r, b_vld_r;
  dfc_mid_t              a_ent_r, b_ent_r;
  logic [SCALED_W-1:0]   a_scaled_r, b_scaled_r;
  logic [CH_W-1:0]       b_q0_r;

  logic [FRAC_W-1:0]     ramp;
  logic [FRAC_W+7:0]     ramp_prod;
  logic [SCALED_W+10:0]  est;
  logic [SCALED_W-1:0]   q0_back, rem;
  logic [CH_W-1:0]       x;
  logic [LW-1:0]         booked;

  // Credit: never launch more than the output queue can still hold
  assign booked  = LW'(out_level) + LW'(a_vld_r) + LW'(b_vld_r);
  assign mid_pop = !mid_empty && (booked < LW'(OUT_DEPTH));

  // Stage A: x * 2^F * 1000 scaled by 255, fraction bits dropped
  assign ramp      = mid_ent.sector[0] ? Unit - mid_ent.frac : mid_ent.frac;
  assign ramp_prod = (FRAC_W+8)'(ramp) * (FRAC_W+8)'(255);

  // Stage B: quotient estimate of the divide by 1000
  assign est = (SCALED_W+11)'(a_scaled_r) * (SCALED_W+11)'(RECIP_1000);

  // Output stage: one-step correction of the estimate
  assign q0_back = SCALED_W'(b_q0_r) * SCALED_W'(SECTOR_MM);
  assign rem     = b_scaled_r - q0_back;
  assign x       = (rem >= SCALED_W'(SECTOR_MM)) ? b_q0_r + 1'b1 : b_q0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= mid_pop;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_ent_r    <= mid_ent;
    a_scaled_r <= SCALED_W'(ramp_prod >> DEPTH_FRACTION_BITS);
    b_ent_r    <= a_ent_r;
    b_scaled_r <= a_scaled_r;
    b_q0_r     <= CH_W'(est >> RECIP_SHIFT);
  end

  assign res_push = b_vld_r;

  always_comb begin
    res.whole_mm    = b_ent_r.whole_mm;
    res.red         = '0;
    res.green       = '0;
    res.blue        = '0;
    res.valid_count = b_ent_r.count;
    res.min_depth   = b_ent_r.min_d;
    res.max_depth   = b_ent_r.max_d;
    res.depth_sum   = b_ent_r.sum;
    res.frame_done  = b_ent_r.last;
    if (b_ent_r.valid) begin
      case (b_ent_r.sector)
        SEC_RED: begin
          res.red = '1;  res.green = x;
        end
        SEC_YEL: begin
          res.red = x;   res.green = '1;
        end
        SEC_GREEN: begin
          res.green = '1; res.blue = x;
        end
        SEC_CYAN: begin
          res.green = x; res.blue = '1;
        end
        default: begin
          res.red = x;   res.blue = '1;
        end
      endcase
    end
  end

endmodule

// ===== sv/depth_false_color_with_stats.sv =====
// Depth false color with per-frame statistics.
//
// Input queue port: one depth pixel per beat (in_depth_q as unsigned Q with
// DEPTH_FRACTION_BITS fraction bits, in_is_finite, in_frame_last). A beat is
// taken on a clock edge with push high and full low.
// Result queue port: one result beat per pixel, in order. The oldest result
// sits on the out_* ports while empty is low and is consumed on an edge with
// pop high. Each result carries integer mm depth, an RGB false color and the
// running valid count / min / max / sum of the frame so far.
// Path: front end, middle queue, back-end stages A and B, result queue.
// Throughput: one pixel per clock, sustained, as long as pop keeps up; the
// statistics accumulators are registered in the front end.
// Stalls: the back end launches pixels only against slots in the 8-deep
// result queue not filled or booked by stages A and B; a 4-deep middle queue
// absorbs the front end, so full rises only once every slot of both is taken.
// Reset (rst_n low, synchronous) empties both queues and returns the
// statistics to their start values; the beat after frame_done starts fresh.
module depth_false_color_with_stats import dfc_pkg::*; #(
  parameter int FRAME_PIXELS_LOG2   = FRAME_PIXELS_LOG2_DEF,
  parameter int DEPTH_FRACTION_BITS = DEPTH_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // pixel input
  input  logic               push,
  output logic               full,
  input  logic [DEPTH_W-1:0] in_depth_q,
  input  logic               in_is_finite,
  input  logic               in_frame_last,
  // result output
  output logic               empty,
  input  logic               pop,
  output logic [MM_W-1:0]    out_whole_mm,
  output logic [CH_W-1:0]    out_red,
  output logic [CH_W-1:0]    out_green,
  output logic [CH_W-1:0]    out_blue,
  output logic [CNT_W-1:0]   out_valid_count,
  output logic [DEPTH_W-1:0] out_min_depth,
  output logic [DEPTH_W-1:0] out_max_depth,
  output logic [SUM_W-1:0]   out_depth_sum,
  output logic               out_frame_done
);

  localparam int MidW = $bits(dfc_mid_t);
  localparam int ResW = $bits(dfc_res_t);

  // front end -> middle queue
  logic                        mid_push, mid_full, mid_empty, mid_pop;
  dfc_mid_t                    mid_in, mid_out;
  logic [$clog2(MID_DEPTH):0]  mid_level;

  // back end -> result queue
  logic                        res_push, res_full;
  dfc_res_t                    res_in, res_out;
  logic [$clog2(OUT_DEPTH):0]  res_level;

  assign full = mid_full;

  // Classify pixel, update running stats
  dfc_front #(
    .FRAME_PIXELS_LOG2   (FRAME_PIXELS_LOG2),
    .DEPTH_FRACTION_BITS (DEPTH_FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .depth_q    (in_depth_q),
    .is_finite  (in_is_finite),
    .frame_last (in_frame_last),
    .mid_full   (mid_full),
    .mid_push   (mid_push),
    .mid_ent    (mid_in)
  );

  // Decouples the stats loop from the color pipeline
  dfc_fifo #(
    .WIDTH (MidW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty),
    .level (mid_level)
  );

  // Color ramp: scale, divide by 1000, sector map
  dfc_back #(
    .DEPTH_FRACTION_BITS (DEPTH_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_ent   (mid_out),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_level (res_level),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue; never overflows thanks to the back-end credit check
  dfc_fifo #(
    .WIDTH (ResW),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty),
    .level (res_level)
  );

  assign out_whole_mm    = res_out.whole_mm;
  assign out_red         = res_out.red;
  assign out_green       = res_out.green;
  assign out_blue        = res_out.blue;
  assign out_valid_count = res_out.valid_count;
  assign out_min_depth   = res_out.min_depth;
  assign out_max_depth   = res_out.max_depth;
  assign out_depth_sum   = res_out.depth_sum;
  assign out_frame_done  = res_out.frame_done;

endmodule

// ===== sv/dfc_chk.sv =====
module dfc_chk import dfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  logic               pop,
  input  logic [MM_W-1:0]    out_whole_mm,
  input  logic [CH_W-1:0]    out_red,
  input  logic [CH_W-1:0]    out_green,
  input  logic [CH_W-1:0]    out_blue,
  input  logic [CNT_W-1:0]   out_valid_count,
  input  logic [DEPTH_W-1:0] out_min_depth,
  input  logic [DEPTH_W-1:0] out_max_depth,
  input  logic [SUM_W-1:0]   out_depth_sum,
  input  logic               out_frame_done
);

  // Nothing left waiting right after reset
  a_reset_empty: assert property (@(posedge clk) (rst_n && !$past(rst_n)) |-> empty)
    else $error("result waiting right after reset");

  // No valid pixel yet in this frame: black, min, max and sum all zero
  a_no_valid_black: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_valid_count == '0) |->
      (out_red == '0 && out_green == '0 && out_blue == '0 &&
       out_min_depth == '0 && out_max_depth == '0 && out_depth_sum == '0))
    else $error("stats or color nonzero with zero valid count");

  // Every color has a zero channel, and a lit color has a full channel
  a_color_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |->
      ((out_red == '0 || out_green == '0 || out_blue == '0) &&
       ((out_red == '0 && out_green == '0 && out_blue == '0) ||
        out_red == '1 || out_green == '1 || out_blue == '1)))
    else $error("false color off the hue ramp");

  // Stats ordering once a valid pixel is counted
  a_stats_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_valid_count != '0) |->
      (out_min_depth <= out_max_depth && out_min_depth != '0 &&
       out_depth_sum >= SUM_W'(out_max_depth)))
    else $error("min/max/sum inconsistent");

  // A waiting result beat holds until popped
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=>
      (!empty && $stable(out_whole_mm) && $stable(out_red) && $stable(out_green) &&
       $stable(out_blue) && $stable(out_valid_count) && $stable(out_depth_sum) &&
       $stable(out_frame_done)))
    else $error("waiting result beat changed");

endmodule

bind depth_false_color_with_stats dfc_chk u_dfc_chk (.*);
